/* design/srit_pkg.sv */
// ----------------------------------------------------------------------------
// Segment intersection test package
// Shared widths, the queued item type and the edge-test stage types.
// ----------------------------------------------------------------------------
package srit_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int NUM_EDGES = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS = 1;

  localparam logic MODE_SEG = 1'b0;
  localparam logic MODE_RECT = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0] diff_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t [NUM_EDGES-1:0] cx;
    coord_t [NUM_EDGES-1:0] cy;
    coord_t [NUM_EDGES-1:0] dx;
    coord_t [NUM_EDGES-1:0] dy;
    logic [NUM_EDGES-1:0] edge_en;
  } edge_set_t;

  typedef struct packed {
    prod_t den_p;
    prod_t den_q;
    prod_t tn_p;
    prod_t tn_q;
    prod_t sn_p;
    prod_t sn_q;
  } prods_t;

endpackage

/* design/segment_rect_intersection_test_unit.sv */
// ----------------------------------------------------------------------------
// Segment intersection test unit
// Tests segment A-B against segment C-D (mode 0) or against the four sides
// of the rectangle with corners C and D (mode 1), and returns one hit bit.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while in_stall is low and returns one hit
// bit per item, in order. An item is written into the two-entry queue after
// the front end, then into the product registers of the back end, and the
// cross terms and bound checks then load the output register; out_stall holds
// the back end. Parallel, collinear and degenerate cases report no hit, and
// touching end points count as a hit.
module segment_rect_intersection_test_unit import srit_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  logic   in_mode,
  input  coord_t in_ax,
  input  coord_t in_ay,
  input  coord_t in_bx,
  input  coord_t in_by,
  input  coord_t in_cx,
  input  coord_t in_cy,
  input  coord_t in_dx,
  input  coord_t in_dy,
  output logic   out_valid,
  input  logic   out_stall,
  output logic   out_hit
);

  logic q_valid, q_take;
  edge_set_t q_data;

  srit_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode,
    .in_ax, .in_ay, .in_bx, .in_by, .in_cx, .in_cy, .in_dx, .in_dy,
    .q_valid, .q_take, .q_data
  );

  srit_back u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_data,
    .out_valid, .out_stall, .out_hit
  );

endmodule

/* design/srit_front.sv */
// ----------------------------------------------------------------------------
// Segment intersection test front end
// Accepts items, expands the mode into up to four C-D segments and queues them.
// ----------------------------------------------------------------------------
module srit_front import srit_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      in_mode,
  input  coord_t    in_ax,
  input  coord_t    in_ay,
  input  coord_t    in_bx,
  input  coord_t    in_by,
  input  coord_t    in_cx,
  input  coord_t    in_cy,
  input  coord_t    in_dx,
  input  coord_t    in_dy,
  output logic      q_valid,
  input  logic      q_take,
  output edge_set_t q_data
);

  edge_set_t mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPTR_BITS:0] cnt_r, cnt_nxt;
  edge_set_t cls;
  logic push, pop;

  always_comb begin
    cls.ax = in_ax;
    cls.ay = in_ay;
    cls.bx = in_bx;
    cls.by = in_by;
    if (in_mode == MODE_RECT) begin
      cls.cx[0] = in_cx; cls.cy[0] = in_cy; cls.dx[0] = in_cx; cls.dy[0] = in_dy;
      cls.cx[1] = in_cx; cls.cy[1] = in_dy; cls.dx[1] = in_dx; cls.dy[1] = in_dy;
      cls.cx[2] = in_dx; cls.cy[2] = in_dy; cls.dx[2] = in_dx; cls.dy[2] = in_cy;
      cls.cx[3] = in_dx; cls.cy[3] = in_cy; cls.dx[3] = in_cx; cls.dy[3] = in_cy;
      cls.edge_en = '1;
    end else begin
      for (int i = 0; i < NUM_EDGES; i++) begin
        cls.cx[i] = in_cx; cls.cy[i] = in_cy; cls.dx[i] = in_dx; cls.dy[i] = in_dy;
      end
      cls.edge_en = {{(NUM_EDGES-1){1'b0}}, 1'b1};
    end
  end

  assign in_stall = (cnt_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != '0);
  assign pop = q_valid && q_take;
  assign q_data = mem_r[rp_r];

  always_comb begin
    wp_nxt = push ? wp_r + 1'b1 : wp_r;
    rp_nxt = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* design/srit_back.sv */
// ----------------------------------------------------------------------------
// Segment intersection test back end
// Two-stage pipeline: products for the four C-D segments, then cross terms and bounds.
// ----------------------------------------------------------------------------
module srit_back import srit_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_take,
  input  edge_set_t q_data,
  output logic      out_valid,
  input  logic      out_stall,
  output logic      out_hit
);

  prods_t p_nxt [NUM_EDGES];
  prods_t p_r [NUM_EDGES];
  logic [NUM_EDGES-1:0] en_r;
  logic v1_r;
  logic v2_r, hit_r, hit_nxt;
  logic adv2, adv1;

  function automatic logic in_unit(input cross_t n, input cross_t d);
    logic r;
    if (d > 0) begin
      r = (n >= 0) && (n <= d);
    end else begin
      r = (n <= 0) && (n >= d);
    end
    return r;
  endfunction

  always_comb begin
    diff_t abx, aby, cdx, cdy, acx, acy;
    abx = DIFF_BITS'(q_data.bx) - DIFF_BITS'(q_data.ax);
    aby = DIFF_BITS'(q_data.by) - DIFF_BITS'(q_data.ay);
    for (int i = 0; i < NUM_EDGES; i++) begin
      cdx = DIFF_BITS'(q_data.dx[i]) - DIFF_BITS'(q_data.cx[i]);
      cdy = DIFF_BITS'(q_data.dy[i]) - DIFF_BITS'(q_data.cy[i]);
      acx = DIFF_BITS'(q_data.cx[i]) - DIFF_BITS'(q_data.ax);
      acy = DIFF_BITS'(q_data.cy[i]) - DIFF_BITS'(q_data.ay);
      p_nxt[i].den_p = abx * cdy;
      p_nxt[i].den_q = aby * cdx;
      p_nxt[i].tn_p = acx * cdy;
      p_nxt[i].tn_q = acy * cdx;
      p_nxt[i].sn_p = acx * aby;
      p_nxt[i].sn_q = acy * abx;
    end
  end

  always_comb begin
    cross_t den, tn, sn;
    hit_nxt = 1'b0;
    for (int i = 0; i < NUM_EDGES; i++) begin
      den = CROSS_BITS'(p_r[i].den_p) - CROSS_BITS'(p_r[i].den_q);
      tn = CROSS_BITS'(p_r[i].tn_p) - CROSS_BITS'(p_r[i].tn_q);
      sn = CROSS_BITS'(p_r[i].sn_p) - CROSS_BITS'(p_r[i].sn_q);
      if (en_r[i] && (den != 0) && in_unit(tn, den) && in_unit(sn, den)) begin
        hit_nxt = 1'b1;
      end
    end
  end

  assign adv2 = !v2_r || !out_stall;
  assign adv1 = !v1_r || adv2;
  assign q_take = adv1;
  assign out_valid = v2_r;
  assign out_hit = hit_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      p_r <= p_nxt;
      en_r <= q_data.edge_en;
    end
    if (adv2) begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= q_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

endmodule

/* dv/segment_rect_intersection_test_unit_test.sv */
// ----------------------------------------------------------------------------
// Segment intersection test unit testbench
// Drives random and corner-case segment and rectangle queries with random
// idling on both sides and checks every hit bit against an exact predictor.
// ----------------------------------------------------------------------------
module segment_rect_intersection_test_unit_test import srit_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic   mode;
    coord_t ax, ay, bx, by, cx, cy, dx, dy;
  } query_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  logic   in_mode = 1'b0;
  coord_t in_ax = '0, in_ay = '0, in_bx = '0, in_by = '0;
  coord_t in_cx = '0, in_cy = '0, in_dx = '0, in_dy = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic   out_hit;

  query_t pending_queries[$];
  logic   expected_hits[$];
  int     mismatch_count = 0;
  int     idle_cycles = 0;
  bit     stimulus_done = 1'b0;
  bit     calm = 1'b0;

  localparam int WATCHDOG_LIMIT = 5000;

  segment_rect_intersection_test_unit dut (.*);

  always #2 clk = ~clk;

  function automatic bit within_unit(longint n, longint d);
    if (d > 0) return n >= 0 && n <= d;
    return n <= 0 && n >= d;
  endfunction

  function automatic bit edge_meets(longint ax, longint ay, longint bx, longint by,
                                    longint cx, longint cy, longint dx, longint dy);
    longint abx, aby, cdx, cdy, acx, acy, den;
    abx = bx - ax; aby = by - ay;
    cdx = dx - cx; cdy = dy - cy;
    acx = cx - ax; acy = cy - ay;
    den = abx * cdy - aby * cdx;
    if (den == 0) return 1'b0;
    if (!within_unit(acx * cdy - acy * cdx, den)) return 1'b0;
    return within_unit(acx * aby - acy * abx, den);
  endfunction

  function automatic logic predict_hit(query_t q);
    if (q.mode == MODE_SEG)
      return edge_meets(q.ax, q.ay, q.bx, q.by, q.cx, q.cy, q.dx, q.dy);
    return edge_meets(q.ax, q.ay, q.bx, q.by, q.cx, q.cy, q.cx, q.dy)
        || edge_meets(q.ax, q.ay, q.bx, q.by, q.cx, q.dy, q.dx, q.dy)
        || edge_meets(q.ax, q.ay, q.bx, q.by, q.dx, q.dy, q.dx, q.cy)
        || edge_meets(q.ax, q.ay, q.bx, q.by, q.dx, q.cy, q.cx, q.cy);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic coord_t rand_coord(int scale);
    case (scale)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 64)) - coord_t'(32);
      default: return coord_t'($urandom_range(0, 4096)) - coord_t'(2048);
    endcase
  endfunction

  task automatic add_query(logic m, coord_t ax, coord_t ay, coord_t bx, coord_t by,
                           coord_t cx, coord_t cy, coord_t dx, coord_t dy);
    query_t q;
    q.mode = m; q.ax = ax; q.ay = ay; q.bx = bx; q.by = by;
    q.cx = cx; q.cy = cy; q.dx = dx; q.dy = dy;
    pending_queries.push_back(q);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_hits.push_back(predict_hit({in_mode, in_ax, in_ay, in_bx,
                                                          in_by, in_cx, in_cy, in_dx, in_dy}));
      if (pending_queries.size() > 0 && (calm || $urandom_range(0, 99) >= 30)) begin
        query_t q;
        q = pending_queries.pop_front();
        in_valid <= 1'b1;
        in_mode <= q.mode;
        in_ax <= q.ax; in_ay <= q.ay; in_bx <= q.bx; in_by <= q.by;
        in_cx <= q.cx; in_cy <= q.cy; in_dx <= q.dx; in_dy <= q.dy;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("result with no item pending");
        end else begin
          logic exp_hit;
          exp_hit = expected_hits.pop_front();
          if (out_hit !== exp_hit)
            report_mismatch($sformatf("hit %b, expected %b", out_hit, exp_hit));
        end
      end
      out_stall <= !calm && $urandom_range(0, 99) < 30;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int n;
    coord_t mx, mn;
    mx = 16'sh7fff; mn = -16'sh8000;
    add_query(MODE_SEG, 0, 0, 10, 10, 0, 10, 10, 0);
    add_query(MODE_SEG, 0, 0, 10, 0, 10, 0, 10, 10);
    add_query(MODE_SEG, 0, 0, 10, 0, 5, 0, 20, 0);
    add_query(MODE_SEG, 0, 0, 10, 0, 0, 5, 10, 5);
    add_query(MODE_SEG, 3, 3, 3, 3, 0, 0, 10, 10);
    add_query(MODE_SEG, 0, 0, 10, 10, 4, 4, 4, 4);
    add_query(MODE_SEG, 0, 0, 10, 10, 11, 0, 0, 11);
    add_query(MODE_SEG, 0, 0, 10, 10, 5, 5, 20, 0);
    add_query(MODE_SEG, mn, mn, mx, mx, mn, mx, mx, mn);
    add_query(MODE_SEG, mx, mn, mn, mx, mx, mx, mn, mn);
    add_query(MODE_SEG, mn, mn, mx, mn, mn, mx, mx, mn);
    add_query(MODE_SEG, mx, mx, mn, mn, mn, mn, mn, mx);
    add_query(MODE_RECT, -20, 0, 20, 0, -10, -10, 10, 10);
    add_query(MODE_RECT, -2, -2, 2, 2, -10, -10, 10, 10);
    add_query(MODE_RECT, 20, 20, 30, 30, -10, -10, 10, 10);
    add_query(MODE_RECT, -20, 0, 20, 0, 10, 10, -10, -10);
    add_query(MODE_RECT, -20, 10, 20, 10, -10, -10, 10, 10);
    add_query(MODE_RECT, 10, 10, 20, 20, -10, -10, 10, 10);
    add_query(MODE_RECT, 0, -20, 0, 20, 5, 5, 5, 5);
    add_query(MODE_RECT, mn, mn, mx, mx, mn, mn, mx, mx);
    add_query(MODE_RECT, mn, 0, mx, 0, mn, mn, mx, mx);
    add_query(MODE_RECT, mx, mx, mx, mx, mn, mn, mx, mx);
    for (int i = 0; i < 1200; i++) begin
      n = $urandom_range(0, 2);
      add_query(logic'($urandom), rand_coord(n), rand_coord(n), rand_coord(n),
                rand_coord(n), rand_coord(n), rand_coord(n), rand_coord(n), rand_coord(n));
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (400) @(posedge clk);
    calm <= 1'b1;
    repeat (300) @(posedge clk);
    calm <= 1'b0;
    while (pending_queries.size() > 0 || in_valid) @(posedge clk);
    n = 0;
    while (expected_hits.size() > 0 && n < 2000) begin
      @(posedge clk);
      n++;
    end
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_hits.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (expected_hits.size() > 0)
        report_mismatch($sformatf("%0d results never arrived", expected_hits.size()));
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
